[rtl/q31bq_pkg.sv]
// shared constants and Q1.31 saturating arithmetic helpers for the biquad prefilter
package q31bq_pkg;

  localparam int DataW   = 32;
  localparam int CfgIdxW = 3;

  typedef logic signed [DataW-1:0] q31_t;

  // coefficient register indexes
  localparam logic [CfgIdxW-1:0] REG_B0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_B1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_B2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_A1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_A2 = 3'd4;

  localparam q31_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q31_t Q_MIN = 32'sh8000_0000;

  // rounded Q1.31 product: (c * x + 2^30) >>> 31, saturated to 32 bits
  function automatic q31_t mul_round(input q31_t c, input q31_t x);
    logic signed [63:0] prod;
    logic signed [64:0] rnd;
    logic signed [33:0] shr;
    q31_t               res;
    prod = 64'(c) * 64'(x);
    rnd  = {prod[63], prod} + (65'sd1 <<< 30);
    shr  = rnd[64:31];
    if (shr > 34'sd2147483647) begin
      res = Q_MAX;
    end else if (shr < -34'sd2147483648) begin
      res = Q_MIN;
    end else begin
      res = shr[31:0];
    end
    return res;
  endfunction

  // saturating 32-bit add
  function automatic q31_t sat_add(input q31_t a, input q31_t b);
    logic signed [32:0] s;
    q31_t               res;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      res = s[32] ? Q_MIN : Q_MAX;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // saturating 32-bit subtract
  function automatic q31_t sat_sub(input q31_t a, input q31_t b);
    logic signed [32:0] s;
    q31_t               res;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      res = s[32] ? Q_MIN : Q_MAX;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // left shift by two with saturation
  function automatic q31_t sat_shl2(input q31_t t);
    q31_t res;
    if ((t[31:29] == 3'b000) || (t[31:29] == 3'b111)) begin
      res = {t[29:0], 2'b00};
    end else begin
      res = t[31] ? Q_MIN : Q_MAX;
    end
    return res;
  endfunction

endpackage

[rtl/q31_biquad_prefilter.sv]
// direct form I biquad prefilter in Q1.31 saturating arithmetic
// an accepted request is held in the input register, then its result is written to the output register
// throughput: one request per cycle while dst_stall is low; the whole filter step (five parallel 32x32
//   multiplies, rounding and saturating adds) sits between the input and result registers
// reset: rst (synchronous) clears valid flags, coefficients and filter history to zero
module q31_biquad_prefilter (
  input  logic                          clk,
  input  logic                          rst,
  // coefficient write port
  input  logic                          cfg_wr_en,
  input  logic [q31bq_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [q31bq_pkg::DataW-1:0]   cfg_data,
  // sample requests
  input  logic                          src_valid,
  output logic                          src_stall,
  input  logic signed [31:0]            sample_in,
  input  logic                          last_in_block,
  // filtered results
  output logic                          dst_valid,
  input  logic                          dst_stall,
  output logic signed [31:0]            sample_out,
  output logic                          last_out
);

  q31bq_pkg::q31_t coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  q31bq_pkg::q31_t prev_in_1, prev_in_2, prev_out_1, prev_out_2;

  logic            in_valid;
  q31bq_pkg::q31_t in_sample;
  logic            in_last;

  logic            advance;
  logic            src_take;

  q31bq_pkg::q31_t pb0, pb1, pb2, pa1, pa2;
  q31bq_pkg::q31_t sum_b, sum_a, diff, y_next;

  // handshake: input stage moves on when the result register is free or being emptied
  assign advance   = in_valid && (!dst_valid || !dst_stall);
  assign src_stall = in_valid && !advance;
  assign src_take  = src_valid && !src_stall;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        q31bq_pkg::REG_B0: coef_b0 <= cfg_data;
        q31bq_pkg::REG_B1: coef_b1 <= cfg_data;
        q31bq_pkg::REG_B2: coef_b2 <= cfg_data;
        q31bq_pkg::REG_A1: coef_a1 <= cfg_data;
        q31bq_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (src_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      in_sample <= sample_in;
      in_last   <= last_in_block;
    end
  end

  // filter step: rounded products, saturating sums, final gain of four
  always_comb begin
    pb0    = q31bq_pkg::mul_round(coef_b0, in_sample);
    pb1    = q31bq_pkg::mul_round(coef_b1, prev_in_1);
    pb2    = q31bq_pkg::mul_round(coef_b2, prev_in_2);
    pa1    = q31bq_pkg::mul_round(coef_a1, prev_out_1);
    pa2    = q31bq_pkg::mul_round(coef_a2, prev_out_2);
    sum_b  = q31bq_pkg::sat_add(q31bq_pkg::sat_add(pb0, pb1), pb2);
    sum_a  = q31bq_pkg::sat_add(pa1, pa2);
    diff   = q31bq_pkg::sat_sub(sum_b, sum_a);
    y_next = q31bq_pkg::sat_shl2(diff);
  end

  // filter history, cleared after the last sample of a block
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_in_1  <= '0;
      prev_in_2  <= '0;
      prev_out_1 <= '0;
      prev_out_2 <= '0;
    end else if (advance) begin
      if (in_last) begin
        prev_in_1  <= '0;
        prev_in_2  <= '0;
        prev_out_1 <= '0;
        prev_out_2 <= '0;
      end else begin
        prev_in_2  <= prev_in_1;
        prev_in_1  <= in_sample;
        prev_out_2 <= prev_out_1;
        prev_out_1 <= y_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= y_next;
      last_out   <= in_last;
    end
  end

endmodule
